>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to drop them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is applied
`define SCB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, active during reset as well
`define SCB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCB_ASSERT(label, clk, rst_n, prop, msg)
`define SCB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/scb_pkg.sv
// ----------------------------------------------------------------------------
// Settings image checker package
// Shared constants, status codes and header, frame and verdict types.
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam logic [31:0] CrcPoly         = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit         = 32'hFFFF_FFFF;
  localparam logic [4:0]  HeaderBytes     = 5'd16;
  localparam logic [31:0] LegacyMapSchema = 32'd4;
  localparam logic [31:0] LegacySchemaB   = 32'd5;
  localparam logic [31:0] LegacySchemaC   = 32'd6;
  localparam logic [31:0] MaxPayload      = 32'd512;
  localparam logic [15:0] CountMax        = 16'hFFFF;
  localparam logic [31:0] MagicReset      = 32'd0;
  localparam logic [31:0] SchemaReset     = 32'd7;

  // Configuration register indexes
  localparam logic CfgMagic  = 1'b0;
  localparam logic CfgSchema = 1'b1;

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusShort    = 3'd1,
    StatusMagic    = 3'd2,
    StatusSchema   = 3'd3,
    StatusLength   = 3'd4,
    StatusTooLong  = 3'd5,
    StatusCrc      = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] schema;
    logic [31:0] length;
    logic [31:0] crc;
  } hdr_t;

  typedef struct packed {
    logic        short_img;
    logic        overflow;
    logic [15:0] count;
    logic [31:0] crc_out;
  } frame_t;

  typedef struct packed {
    status_e status;
    logic    map_reset;
  } verdict_t;

endpackage

>>> rtl/scb_crc_byte.sv
// ----------------------------------------------------------------------------
// CRC-32 byte update
// Reflected CRC-32 advanced by one byte, eight bit steps unrolled.
// ----------------------------------------------------------------------------
module scb_crc_byte (
  input  logic [31:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);

  always_comb begin
    logic [31:0] c;
    c = crc_i ^ {24'd0, data_i};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ scb_pkg::CrcPoly) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

>>> rtl/scb_verdict.sv
// ----------------------------------------------------------------------------
// Image verdict
// Priority checks on header and payload; the first failing check wins.
// ----------------------------------------------------------------------------
module scb_verdict (
  input  scb_pkg::hdr_t     hdr_i,
  input  scb_pkg::frame_t   frame_i,
  input  logic [31:0]       expected_magic_i,
  input  logic [31:0]       current_schema_i,
  output scb_pkg::verdict_t verdict_o
);

  logic schema_ok;
  logic len_bad;

  assign schema_ok = (hdr_i.schema == current_schema_i) ||
                     (hdr_i.schema == scb_pkg::LegacyMapSchema) ||
                     (hdr_i.schema == scb_pkg::LegacySchemaB) ||
                     (hdr_i.schema == scb_pkg::LegacySchemaC);
  assign len_bad = frame_i.overflow || (hdr_i.length != {16'd0, frame_i.count});

  always_comb begin
    verdict_o.map_reset = 1'b0;
    if (frame_i.short_img) begin
      verdict_o.status = scb_pkg::StatusShort;
    end else begin
      verdict_o.map_reset = (hdr_i.schema == scb_pkg::LegacyMapSchema);
      if (hdr_i.magic != expected_magic_i) begin
        verdict_o.status = scb_pkg::StatusMagic;
      end else if (!schema_ok) begin
        verdict_o.status = scb_pkg::StatusSchema;
      end else if (len_bad) begin
        verdict_o.status = scb_pkg::StatusLength;
      end else if (hdr_i.length > scb_pkg::MaxPayload) begin
        verdict_o.status = scb_pkg::StatusTooLong;
      end else if (frame_i.crc_out != hdr_i.crc) begin
        verdict_o.status = scb_pkg::StatusCrc;
      end else begin
        verdict_o.status = scb_pkg::StatusOk;
      end
    end
  end

endmodule

>>> rtl/settings_blob_crc_checker.sv
// ----------------------------------------------------------------------------
// Settings image CRC checker
// Streams a settings image byte by byte, collects the 16-byte header,
// runs CRC-32 over the payload and gives one verdict word per image.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------
//   input    | in_valid_i / in_stall_o     | data_byte_i, final_byte_i
//   output   | out_valid_o / out_stall_i   | status_o, needs_map_reset_o,
//            |                             | computed_crc_o, payload_count_o
//   config   | cfg_we_i (no wait)          | cfg_index_i, cfg_wdata_i
//
// One byte is taken per cycle while the input is not stalled; the byte-wide
// CRC update and the header capture finish in the cycle the byte is accepted.
// A verdict appears in the cycle after the final byte, from the result register.
// The input stalls only while a verdict waits and the output is stalled.
// Reset clears the frame state and loads the register defaults; no sweep.
//
module settings_blob_crc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  // verdicts
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        needs_map_reset_o,
  output logic [31:0] computed_crc_o,
  output logic [15:0] payload_count_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

`include "assert_macros.svh"

  // Configuration registers
  logic [31:0] magic_cfg_q;
  logic [31:0] schema_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_cfg_q  <= scb_pkg::MagicReset;
      schema_cfg_q <= scb_pkg::SchemaReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scb_pkg::CfgMagic:  magic_cfg_q  <= cfg_wdata_i;
        scb_pkg::CfgSchema: schema_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame state
  scb_pkg::hdr_t hdr_q, hdr_d;
  logic [4:0]    hdr_pos_q, hdr_pos_d;
  logic [15:0]   count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [31:0]   crc_q, crc_d, crc_upd;

  logic in_acc;
  logic out_valid_q;

  // Hold new bytes only while a finished verdict cannot leave
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  scb_crc_byte u_crc (
    .crc_i  (crc_q),
    .data_i (data_byte_i),
    .crc_o  (crc_upd)
  );

  // Frame state after taking this byte (before the end-of-image clear)
  always_comb begin
    hdr_d     = hdr_q;
    hdr_pos_d = hdr_pos_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    crc_d     = crc_q;
    if (hdr_pos_q < scb_pkg::HeaderBytes) begin
      // Little-endian: lane set by the low two bits of the position
      case (hdr_pos_q[3:2])
        2'd0:    hdr_d.magic[{hdr_pos_q[1:0], 3'b000} +: 8]  = data_byte_i;
        2'd1:    hdr_d.schema[{hdr_pos_q[1:0], 3'b000} +: 8] = data_byte_i;
        2'd2:    hdr_d.length[{hdr_pos_q[1:0], 3'b000} +: 8] = data_byte_i;
        default: hdr_d.crc[{hdr_pos_q[1:0], 3'b000} +: 8]    = data_byte_i;
      endcase
      hdr_pos_d = hdr_pos_q + 5'd1;
    end else begin
      crc_d = crc_upd;
      if (count_q < scb_pkg::CountMax) begin
        count_d = count_q + 16'd1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q     <= '0;
      hdr_pos_q <= '0;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      crc_q     <= scb_pkg::CrcInit;
    end else if (in_acc) begin
      if (final_byte_i) begin
        // Drop the frame and start afresh for the next image
        hdr_q     <= '0;
        hdr_pos_q <= '0;
        count_q   <= '0;
        ovf_q     <= 1'b0;
        crc_q     <= scb_pkg::CrcInit;
      end else begin
        hdr_q     <= hdr_d;
        hdr_pos_q <= hdr_pos_d;
        count_q   <= count_d;
        ovf_q     <= ovf_d;
        crc_q     <= crc_d;
      end
    end
  end

  // Verdict on the updated frame
  scb_pkg::frame_t   frame;
  scb_pkg::verdict_t verdict;

  assign frame.short_img = (hdr_pos_d < scb_pkg::HeaderBytes);
  assign frame.overflow  = ovf_d;
  assign frame.count     = count_d;
  assign frame.crc_out   = ~crc_d;

  scb_verdict u_verdict (
    .hdr_i            (hdr_d),
    .frame_i          (frame),
    .expected_magic_i (magic_cfg_q),
    .current_schema_i (schema_cfg_q),
    .verdict_o        (verdict)
  );

  // Result register
  scb_pkg::status_e status_q;
  logic             map_reset_q;
  logic [31:0]      crc_out_q;
  logic [15:0]      bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && final_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload needs no reset; load only with a new verdict
  always_ff @(posedge clk_i) begin
    if (in_acc && final_byte_i) begin
      status_q    <= verdict.status;
      map_reset_q <= verdict.map_reset;
      crc_out_q   <= frame.crc_out;
      bytes_q     <= frame.count;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign needs_map_reset_o = map_reset_q;
  assign computed_crc_o    = crc_out_q;
  assign payload_count_o   = bytes_q;

  // Assertions
  `SCB_ASSERT(a_hdr_pos_range, clk_i, rst_ni, hdr_pos_q <= scb_pkg::HeaderBytes,
              "header position past header")
  `SCB_ASSERT(a_final_gives_verdict, clk_i, rst_ni,
              in_acc && final_byte_i |=> out_valid_q, "final byte gave no verdict")
  `SCB_ASSERT(a_final_clears_frame, clk_i, rst_ni,
              in_acc && final_byte_i |=> hdr_pos_q == 5'd0 &&
              crc_q == scb_pkg::CrcInit && count_q == 16'd0,
              "frame not cleared after final byte")
  `SCB_ASSERT(a_short_no_map_reset, clk_i, rst_ni,
              out_valid_q && status_q == scb_pkg::StatusShort |-> !map_reset_q,
              "map reset flagged on short image")

endmodule
